>>> design/kth_order_statistic_select_macros.svh
// assertion macros for the k-th order statistic selector
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef KTH_ORDER_STATISTIC_SELECT_MACROS_SVH
`define KTH_ORDER_STATISTIC_SELECT_MACROS_SVH

// same-cycle implication, checked outside reset
`define KOS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kos check failed");

// next-cycle implication, checked outside reset
`define KOS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kos check failed");

`endif

>>> design/kos_pkg.sv
// shared types, widths and helpers for the k-th order statistic selector
// no dependencies
package kos_pkg;

    localparam int MAX_K    = 64;
    localparam int DATA_W   = 32;
    localparam int RANK_W   = 7;
    localparam int CNT_W    = $clog2(MAX_K + 1);
    localparam int IDX_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CMP_W    = (RANK_W > CNT_W) ? RANK_W : CNT_W;
    localparam int GRP_SIZE = 8;
    localparam int NUM_GRP  = (MAX_K + GRP_SIZE - 1) / GRP_SIZE;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd1;

    // link between neighboring cells
    typedef struct packed {
        logic              shift;
        logic [DATA_W-1:0] value;
    } t_link;

    // finished item waiting for readout
    typedef struct packed {
        logic             valid;
        logic             status;
        logic [IDX_W-1:0] idx;
    } t_pend;

    // unsigned key, smaller is better under the given mode
    function automatic logic [DATA_W-1:0] sort_key(input logic [DATA_W-1:0] value,
                                                   input logic mode);
        logic [DATA_W-1:0] k;
        k = value ^ {1'b1, {(DATA_W-1){1'b0}}};
        return mode ? ~k : k;
    endfunction

endpackage

>>> design/kos_item_if.sv
// input channel of the selector: one sample per beat
// depends on kos_pkg
interface kos_item_if;
    logic                        valid;
    logic                        ready;
    logic signed [kos_pkg::DATA_W-1:0] sample;
    logic                        is_last;

    modport source (output valid, output sample, output is_last, input ready);
    modport sink   (input valid, input sample, input is_last, output ready);
endinterface

>>> design/kos_result_if.sv
// result channel of the selector: one order statistic per beat
// depends on kos_pkg
interface kos_result_if;
    logic                        valid;
    logic                        ready;
    logic signed [kos_pkg::DATA_W-1:0] selected;
    logic                        status;

    modport source (output valid, output selected, output status, input ready);
    modport sink   (input valid, input selected, input status, output ready);
endinterface

>>> design/kos_cell.sv
// one slot of the sorted insertion chain
// depends on kos_pkg
module kos_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic                       i_mode,
    input  logic [kos_pkg::DATA_W-1:0] i_sample,
    input  logic [kos_pkg::DATA_W-1:0] i_key,
    input  kos_pkg::t_link             i_prev,
    output kos_pkg::t_link             o_next
);
    import kos_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              worse;

    // this slot gives way when empty or when it holds a worse entry
    assign worse = !i_valid || (sort_key(r_value, i_mode) > i_key);

    // the insertion point and everything after it moves down one slot
    assign o_next.shift = i_prev.shift | worse;
    assign o_next.value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_prev.shift) begin
            n_value = i_prev.value;
        end else if (worse) begin
            n_value = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

endmodule

>>> design/kos_pick.sv
// readout of one slot of the chain through a two-stage registered or-tree
// depends on kos_pkg and kos_result_if
module kos_pick (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [kos_pkg::DATA_W-1:0] i_values [kos_pkg::MAX_K],
    input  kos_pkg::t_pend             i_pend,
    output logic                       o_take,
    kos_result_if.source               o_result
);
    import kos_pkg::*;

    logic              r_g_valid;
    logic              r_g_status;
    logic [DATA_W-1:0] r_grp [NUM_GRP];
    logic [DATA_W-1:0] n_grp [NUM_GRP];
    logic              r_o_valid;
    logic              r_o_status;
    logic [DATA_W-1:0] r_o_sel;
    logic [DATA_W-1:0] n_sel;
    logic              out_move;

    assign out_move = !r_o_valid || o_result.ready;
    assign o_take   = !r_g_valid || out_move;

    // first level: masked slots or-ed within each group
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp[g] = '0;
        end
        for (int i = 0; i < MAX_K; i++) begin
            if (i_pend.idx == IDX_W'(i)) begin
                n_grp[i / GRP_SIZE] = n_grp[i / GRP_SIZE] | i_values[i];
            end
        end
    end

    // second level: only the group holding the slot is nonzero
    always_comb begin
        n_sel = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_sel = n_sel | r_grp[g];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_g_valid <= i_pend.valid;
            end
            if (out_move) begin
                r_o_valid <= r_g_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (o_take && i_pend.valid) begin
            r_grp      <= n_grp;
            r_g_status <= i_pend.status;
        end
        if (out_move && r_g_valid) begin
            r_o_sel    <= r_g_status ? '0 : n_sel;
            r_o_status <= r_g_status;
        end
    end

    assign o_result.valid    = r_o_valid;
    assign o_result.selected = r_o_sel;
    assign o_result.status   = r_o_status;

endmodule

>>> design/kth_order_statistic_select.sv
// top level of the streaming k-th smallest / largest selector
// depends on kos_pkg, kos_item_if, kos_result_if, kos_cell, kos_pick
//
//   channel    dir  payload              beat ends
//   i_item     in   sample, is_last      stream sample, marked last closes stream
//   o_result   out  selected, status     one beat per closed stream
//   i_cfg_*    in   rank, order_mode     single-cycle register write
//
// one sample per cycle unless the input stalls; every cell compares against the new sample in parallel
// after the last beat the result passes the pending slot, the group or register and the output register
// input stalls only while the readout pipe is full, the output is not ready and a pending result waits
// synchronous active-low reset clears count and pipe valids, sets rank to 1 and mode to 0
`include "kth_order_statistic_select_macros.svh"

module kth_order_statistic_select (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kos_item_if.sink                      i_item,
    kos_result_if.source                  o_result,
    input  logic                          i_cfg_we,
    input  logic [kos_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kos_pkg::RANK_W-1:0]    i_cfg_data
);
    import kos_pkg::*;

    logic [RANK_W-1:0] r_rank;
    logic              r_mode;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_pend             r_pend;
    t_pend             n_pend;
    logic              in_beat;
    logic              pick_take;
    logic [DATA_W-1:0] key_new;
    logic [CNT_W-1:0]  post_count;
    logic [CMP_W-1:0]  rank_ext;
    logic              rank_ok;
    t_link             links [MAX_K+1];
    logic [DATA_W-1:0] values [MAX_K];

    // input handshake
    assign i_item.ready = !r_pend.valid || pick_take;
    assign in_beat      = i_item.valid && i_item.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= RANK_W'(1);
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RANK: r_rank <= i_cfg_data;
                REG_MODE: r_mode <= i_cfg_data[0];
                default:  r_rank <= r_rank;
            endcase
        end
    end

    // insertion chain
    assign key_new  = sort_key(i_item.sample, r_mode);
    assign links[0] = '0;

    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        kos_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (in_beat),
            .i_valid  (r_count > CNT_W'(i)),
            .i_mode   (r_mode),
            .i_sample (i_item.sample),
            .i_key    (key_new),
            .i_prev   (links[i]),
            .o_next   (links[i+1])
        );
        assign values[i] = links[i+1].value;
    end

    // fill count and result status
    assign post_count = (r_count < CNT_W'(MAX_K)) ? r_count + 1'b1 : CNT_W'(MAX_K);
    assign rank_ext   = CMP_W'(r_rank);
    assign rank_ok    = (rank_ext != '0) && (rank_ext <= CMP_W'(MAX_K))
                        && (rank_ext <= CMP_W'(post_count));

    always_comb begin
        n_count = r_count;
        n_pend  = r_pend;
        if (pick_take) begin
            n_pend.valid = 1'b0;
        end
        if (in_beat) begin
            n_count = i_item.is_last ? '0 : post_count;
            if (i_item.is_last) begin
                n_pend.valid  = 1'b1;
                n_pend.status = !rank_ok;
                n_pend.idx    = IDX_W'(rank_ext - 1'b1);
            end
        end
    end

    // count and pending slot, only the count and the valid flag are reset
    always_ff @(posedge i_clk) begin
        r_pend.status <= n_pend.status;
        r_pend.idx    <= n_pend.idx;
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend.valid <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_pend.valid <= n_pend.valid;
        end
    end

    // readout of the selected slot
    kos_pick u_pick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_values (values),
        .i_pend   (r_pend),
        .o_take   (pick_take),
        .o_result (o_result)
    );

    // checks
    `KOS_ASSERT_NEXT(a_count_cleared, in_beat && i_item.is_last, r_count == '0)
    `KOS_ASSERT_NEXT(a_pend_set, in_beat && i_item.is_last, r_pend.valid)
    `KOS_ASSERT_NOW(a_hold_chain, r_pend.valid && !pick_take, !i_item.ready)
    `KOS_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(MAX_K))

endmodule
